// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper: shared package
// Word types for both channels, the classified byte that passes between
// the front and back parts, and the character and UTF-8 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Input word: one raw byte of the escaped string body.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } raw_word_t;

  // Result word: one unescaped byte or a bare end marker.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       run_last;
  } res_word_t;

  // A raw byte with everything the back part needs to know about it.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_bslash;
    logic       is_u;
    logic       is_hex;
    logic [3:0] nib;
    logic [7:0] esc_byte;
  } class_t;

  // One entry of the queue between the front and back parts.
  typedef struct packed {
    class_t cls;
    logic   last;
  } q_entry_t;

  // Characters of interest.
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  // Control bytes produced by the short escapes.
  localparam logic [7:0] CTRL_LF  = 8'h0A;
  localparam logic [7:0] CTRL_TAB = 8'h09;
  localparam logic [7:0] CTRL_CR  = 8'h0D;
  localparam logic [7:0] CTRL_BS  = 8'h08;
  localparam logic [7:0] CTRL_FF  = 8'h0C;

  // Value of the first letter digit.
  localparam logic [3:0] HEX_ALPHA_OFS = 4'd10;

  // UTF-8 encoding limits and marks.
  localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF_LEAD2    = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3    = 8'hE0;
  localparam logic [7:0]  UTF_CONT     = 8'h80;

endpackage : jsu_pkg

`default_nettype wire

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// JSON string unescaper: front part
// Accepts raw words and classifies each byte (backslash, escape letter,
// hex digit and its value) before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  logic              raw_valid,
  output logic              raw_stall,
  input  jsu_pkg::raw_word_t raw_word,
  input  logic              q_full,
  output logic              q_push,
  output jsu_pkg::q_entry_t q_data
);
  import jsu_pkg::*;

  logic [7:0] b;
  logic       is_digit;
  logic       is_lower;
  logic       is_upper;

  // The queue being full is the only reason to hold the source off.
  assign raw_stall = q_full;
  assign q_push    = raw_valid && !q_full;

  assign b        = raw_word.in_byte;
  assign is_digit = (b >= CH_DIGIT_0) && (b <= CH_DIGIT_9);
  assign is_lower = (b >= CH_LOWER_A) && (b <= CH_LOWER_F);
  assign is_upper = (b >= CH_UPPER_A) && (b <= CH_UPPER_F);

  // Classification of the incoming byte.
  always_comb begin
    q_data.last          = raw_word.last_in;
    q_data.cls.byte_val  = b;
    q_data.cls.is_bslash = (b == CH_BSLASH);
    q_data.cls.is_u      = (b == CH_U);
    q_data.cls.is_hex    = is_digit || is_lower || is_upper;

    if (is_lower) begin
      q_data.cls.nib = 4'(b - CH_LOWER_A) + HEX_ALPHA_OFS;
    end else if (is_upper) begin
      q_data.cls.nib = 4'(b - CH_UPPER_A) + HEX_ALPHA_OFS;
    end else begin
      q_data.cls.nib = b[3:0];
    end

    // Byte that an escape with this letter stands for.
    unique case (b)
      CH_N:    q_data.cls.esc_byte = CTRL_LF;
      CH_T:    q_data.cls.esc_byte = CTRL_TAB;
      CH_R:    q_data.cls.esc_byte = CTRL_CR;
      CH_B:    q_data.cls.esc_byte = CTRL_BS;
      CH_F:    q_data.cls.esc_byte = CTRL_FF;
      default: q_data.cls.esc_byte = b;
    endcase
  end

endmodule : jsu_front

`default_nettype wire

// File: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// JSON string unescaper: decoupling queue
// A short first-in first-out queue of classified bytes between the front
// and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jsu_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output jsu_pkg::q_entry_t head
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Storage; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : jsu_queue

`default_nettype wire

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// JSON string unescaper: back part
// Runs the escape state machine on one byte at a time, closing its results
// before taking the next; holds the four bytes after a backslash-u, sends
// UTF-8 and replays invalid hex; one result waits until its word's end is known.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  jsu_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output jsu_pkg::res_word_t res_word
);
  import jsu_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_TAKE   = 2'd0;
  localparam logic [1:0] ST_UTF    = 2'd1;
  localparam logic [1:0] ST_REPLAY = 2'd2;
  localparam logic [1:0] ST_FLUSH  = 2'd3;

  // Escape modes.
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  logic [1:0] state, state_next;
  logic [1:0] mode, mode_next;
  logic [1:0] hcnt, hcnt_next;
  logic [1:0] ridx, ridx_next;
  logic       utf_two, utf_two_next;
  logic [5:0] utf_mid, utf_mid_next;
  logic [5:0] utf_low, utf_low_next;
  logic       item_last;
  logic       pend_valid;
  logic [7:0] pend_byte;
  class_t     hold [4];

  logic       out_free;
  logic       step_go;
  class_t     src;
  logic       hold_we;
  logic       gen_valid;
  logic [7:0] gen_byte;
  logic       flush_go;
  logic       all_hex;
  logic [15:0] cp;

  assign out_free = !res_valid || !res_stall;
  assign src      = (state == ST_REPLAY) ? hold[ridx] : q_head.cls;
  assign step_go  = out_free &&
                    (((state == ST_TAKE) && q_valid) || (state == ST_REPLAY));
  assign q_pop    = step_go && (state == ST_TAKE);
  assign flush_go = out_free && (state == ST_FLUSH);

  // The code point from the three held digits and the current one.
  assign all_hex = hold[0].is_hex && hold[1].is_hex && hold[2].is_hex && src.is_hex;
  assign cp      = {hold[0].nib, hold[1].nib, hold[2].nib, src.nib};

  // Escape state machine step and sequencer.
  always_comb begin
    state_next   = state;
    mode_next    = mode;
    hcnt_next    = hcnt;
    ridx_next    = ridx;
    utf_two_next = utf_two;
    utf_mid_next = utf_mid;
    utf_low_next = utf_low;
    hold_we      = 1'b0;
    gen_valid    = 1'b0;
    gen_byte     = src.byte_val;

    if (step_go) begin
      // Where the word's work goes after this byte, unless a case below says.
      if ((state == ST_REPLAY) && (ridx != 2'd3)) begin
        ridx_next = ridx + 1'b1;
      end else begin
        state_next = ST_FLUSH;
      end

      unique case (mode)
        MODE_ESCAPE: begin
          mode_next = MODE_NORMAL;
          if (src.is_u) begin
            mode_next = MODE_HEX;
            hcnt_next = 2'd0;
          end else begin
            gen_valid = 1'b1;
            gen_byte  = src.esc_byte;
          end
        end
        MODE_HEX: begin
          hold_we = 1'b1;
          if (hcnt == 2'd3) begin
            mode_next = MODE_NORMAL;
            hcnt_next = 2'd0;
            gen_valid = 1'b1;
            if (!all_hex) begin
              // Send the letter and run the four held bytes again.
              gen_byte   = CH_U;
              state_next = ST_REPLAY;
              ridx_next  = 2'd0;
            end else if (cp < CP_ONE_LIMIT) begin
              gen_byte = cp[7:0];
            end else if (cp < CP_TWO_LIMIT) begin
              gen_byte     = UTF_LEAD2 | {3'b000, cp[10:6]};
              utf_two_next = 1'b0;
              utf_low_next = cp[5:0];
              state_next   = ST_UTF;
            end else begin
              gen_byte     = UTF_LEAD3 | {4'b0000, cp[15:12]};
              utf_two_next = 1'b1;
              utf_mid_next = cp[11:6];
              utf_low_next = cp[5:0];
              state_next   = ST_UTF;
            end
          end else begin
            hcnt_next = hcnt + 1'b1;
          end
        end
        default: begin
          // Normal mode; the unused code behaves the same.
          mode_next = MODE_NORMAL;
          if (src.is_bslash) begin
            mode_next = MODE_ESCAPE;
          end else begin
            gen_valid = 1'b1;
          end
        end
      endcase
    end else if (out_free && (state == ST_UTF)) begin
      // Continuation bytes of a UTF-8 sequence.
      gen_valid = 1'b1;
      if (utf_two) begin
        gen_byte     = UTF_CONT | {2'b00, utf_mid};
        utf_two_next = 1'b0;
      end else begin
        gen_byte   = UTF_CONT | {2'b00, utf_low};
        state_next = ST_FLUSH;
      end
    end else if (flush_go) begin
      // The end of a string drops any unfinished escape.
      state_next = ST_TAKE;
      if (item_last) begin
        mode_next = MODE_NORMAL;
        hcnt_next = 2'd0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_TAKE;
      mode       <= MODE_NORMAL;
      hcnt       <= 2'd0;
      ridx       <= 2'd0;
      utf_two    <= 1'b0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      mode    <= mode_next;
      hcnt    <= hcnt_next;
      ridx    <= ridx_next;
      utf_two <= utf_two_next;

      if (gen_valid) begin
        // A new byte pushes the kept one out, which cannot be the last.
        pend_valid <= 1'b1;
        res_valid  <= pend_valid;
      end else if (flush_go) begin
        pend_valid <= 1'b0;
        res_valid  <= pend_valid || item_last;
      end else if (out_free) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    utf_mid <= utf_mid_next;
    utf_low <= utf_low_next;
    if (q_pop) begin
      item_last <= q_head.last;
    end
    if (hold_we) begin
      hold[hcnt] <= src;
    end
    if (gen_valid) begin
      pend_byte <= gen_byte;
      if (pend_valid) begin
        res_word.out_byte   <= pend_byte;
        res_word.byte_valid <= 1'b1;
        res_word.string_end <= 1'b0;
        res_word.run_last   <= 1'b0;
      end
    end else if (flush_go) begin
      if (pend_valid) begin
        res_word.out_byte   <= pend_byte;
        res_word.byte_valid <= 1'b1;
      end else begin
        res_word.out_byte   <= 8'h00;
        res_word.byte_valid <= 1'b0;
      end
      res_word.string_end <= item_last;
      res_word.run_last   <= 1'b1;
    end
  end

endmodule : jsu_back

`default_nettype wire

// File: rtl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// JSON string unescaper
// Turns the raw bytes of a JSON string body into unescaped bytes, with
// backslash-u sequences sent as UTF-8.
// ----------------------------------------------------------------------------
//   Channel | Handshake             | Word
//   --------+-----------------------+---------------------------------------
//   raw     | raw_valid / raw_stall | in_byte, last_in
//   res     | res_valid / res_stall | out_byte, byte_valid, string_end,
//           |                       | run_last
//
// An ordinary byte or short escape passes the back part as an escape step and then a flush
// that closes the word's results. A valid backslash-u sends its UTF-8 continuation bytes
// from ST_UTF; an invalid one replays the four held bytes through the same step logic. The
// queue of QUEUE_DEPTH words lets the front keep taking bytes while the back part works.
// Reset is synchronous and clears the queue, escape state and result valid; a stalled
// result holds the back part but not the front until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               raw_valid,
  output logic               raw_stall,
  input  jsu_pkg::raw_word_t raw_word,
  output logic               res_valid,
  input  logic               res_stall,
  output jsu_pkg::res_word_t res_word
);
  import jsu_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_data;
  q_entry_t q_head;

  // Classification of incoming bytes.
  jsu_front u_front (
    .raw_valid (raw_valid),
    .raw_stall (raw_stall),
    .raw_word  (raw_word),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  // Decoupling queue.
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Escape processing and result output.
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule : json_string_unescape

`default_nettype wire

// File: rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// JSON string unescaper: port checker
// Checks the result channel and reset behaviour as seen at the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_checker (
  input logic               clk,
  input logic               rst,
  input logic               raw_stall,
  input logic               res_valid,
  input logic               res_stall,
  input jsu_pkg::res_word_t res_word
);
  import jsu_pkg::*;

  // A stalled result word stays put.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("stalled result word changed");

  // The end of a string is always the last word of its input byte.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.string_end |-> res_word.run_last)
    else $error("string end without run end");

  // A word without data is only ever the bare end marker.
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_word.byte_valid |->
      res_word.string_end && res_word.out_byte == 8'h00)
    else $error("empty word that is not a clean end marker");

  // Straight after reset nothing is pending and input is open.
  a_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && !raw_stall)
    else $error("block not empty after reset");

endmodule : jsu_checker

bind json_string_unescape jsu_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .raw_stall (raw_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_word  (res_word)
);

`default_nettype wire
